[rtl/core/ple_pkg.sv]
// Shared types and codes for the positional list engine.
// Used by ple_ctrl, ple_datapath and positional_list_engine; depends on nothing.
`default_nettype none

package ple_pkg;

    // Command codes carried by a request.
    typedef enum logic [2:0] {
        CMD_CLEAR  = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_GET    = 3'd3,
        CMD_LOCATE = 3'd4,
        CMD_DUMP   = 3'd5
    } t_cmd;

    // Result status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_POS  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the request fields
        logic check;   // evaluate the request and set up the walk
        logic rd;      // read the store at the walk index and step it
        logic finish;  // final update of length and store, closing result
    } t_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic report;  // request ends with an immediate result
        logic walk;    // request needs a walk over the store
        logic at_end;  // walk index sits on its last entry
    } t_stat;

endpackage

`default_nettype wire

[rtl/core/ple_ctrl.sv]
// Sequencing state machine of the positional list engine.
// Depends on ple_pkg for the command and status structs.
`default_nettype none

module ple_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    output logic                o_busy,
    output ple_pkg::t_ctl       o_ctl,
    input  wire ple_pkg::t_stat i_stat
);
    import ple_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_WALK   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_ctl.check = 1'b1;
                if (i_stat.report) begin
                    n_state = S_IDLE;
                end else if (i_stat.walk) begin
                    n_state = S_WALK;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_WALK: begin
                o_ctl.rd = 1'b1;
                if (i_stat.at_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // The last read word is consumed by the datapath here.
                n_state = S_FINISH;
            end
            S_FINISH: begin
                o_ctl.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

[rtl/core/ple_datapath.sv]
// Element store, length, walk pointer and result registers of the list engine.
// Depends on ple_pkg; driven by ple_ctrl through t_ctl and answers with t_stat.
`default_nettype none

module ple_datapath #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ple_pkg::t_ctl      i_ctl,
    output ple_pkg::t_stat          o_stat,
    input  wire logic        [2:0]  i_cmd,
    input  wire logic signed [7:0]  i_position,
    input  wire logic signed [31:0] i_value_in,
    output logic                    o_strobe,
    output logic             [2:0]  o_status,
    output logic signed      [31:0] o_value_out,
    output logic             [6:0]  o_count,
    output logic                    o_last
);
    import ple_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = ((LW > 8) ? LW : 8) + 1;

    // Element store: one write port, one registered read port.
    logic [DATA_WIDTH-1:0] mem [CAPACITY];
    logic [DATA_WIDTH-1:0] r_rdata;

    // Captured request.
    t_cmd                  r_cmd;
    logic signed [7:0]     r_pos;
    logic [DATA_WIDTH-1:0] r_val;

    // List length and walk state.
    logic [LW-1:0] r_len;
    logic [LW-1:0] n_len;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_end;
    logic          r_down;
    logic          r_rv;
    logic [AW-1:0] r_ri;
    logic          r_found;

    logic signed [63:0] v64;
    logic signed [63:0] rd64;
    logic [LW+6:0]      cnt_ext;

    logic          pos_pos;
    logic [CW-1:0] pos_u;
    logic [CW-1:0] len_c;
    logic          ins_ok;
    logic          del_ok;
    logic          full;
    logic          empty;
    logic [AW-1:0] len_m1;
    logic [AW-1:0] pos_m1;
    logic [AW-1:0] pos_ix;
    logic [AW-1:0] ri_p1;
    logic [AW-1:0] ri_m1;

    logic          plan_report;
    logic          plan_walk;
    logic [2:0]    plan_code;
    logic [AW-1:0] walk_start;
    logic [AW-1:0] walk_end;
    logic          walk_down;

    logic                  we;
    logic [AW-1:0]         wa;
    logic [DATA_WIDTH-1:0] wd;

    logic                  e_vld;
    logic [2:0]            e_status;
    logic signed [31:0]    e_value;
    logic                  e_last;

    // Input value cut to the stored width after sign extension.
    assign v64 = 64'(i_value_in);

    // Stored word sign-extended back to the 32-bit result field.
    assign rd64 = 64'(signed'(r_rdata));

    // Position checks against the current length.
    assign pos_pos = !r_pos[7] && (r_pos != 8'sd0);
    assign pos_u   = CW'(r_pos[6:0]);
    assign len_c   = CW'(r_len);
    assign ins_ok  = pos_pos && (pos_u <= len_c + CW'(1));
    assign del_ok  = pos_pos && (pos_u <= len_c);
    assign full    = (r_len >= LW'(CAPACITY));
    assign empty   = (r_len == '0);
    assign len_m1  = AW'(r_len - LW'(1));
    assign pos_m1  = AW'(pos_u - CW'(1));
    assign pos_ix  = AW'(pos_u);
    assign ri_p1   = r_ri + AW'(1);
    assign ri_m1   = r_ri - AW'(1);

    // Plan for the captured request: immediate result, walk, or straight to finish.
    always_comb begin
        plan_report = 1'b0;
        plan_walk   = 1'b0;
        plan_code   = ST_OK;
        walk_start  = '0;
        walk_end    = len_m1;
        walk_down   = 1'b0;
        unique case (r_cmd)
            CMD_CLEAR: begin
                plan_report = 1'b0;
            end
            CMD_INSERT: begin
                if (!ins_ok) begin
                    plan_report = 1'b1;
                    plan_code   = ST_BAD_POS;
                end else if (full) begin
                    plan_report = 1'b1;
                    plan_code   = ST_FULL;
                end else if (pos_u != len_c + CW'(1)) begin
                    // Shift the tail up, from the last entry down to the position.
                    plan_walk  = 1'b1;
                    walk_start = len_m1;
                    walk_end   = pos_m1;
                    walk_down  = 1'b1;
                end
            end
            CMD_DELETE: begin
                if (!del_ok) begin
                    plan_report = 1'b1;
                    plan_code   = ST_BAD_POS;
                end else if (pos_u != len_c) begin
                    // Shift the tail down, from just past the position to the end.
                    plan_walk  = 1'b1;
                    walk_start = pos_ix;
                end
            end
            CMD_GET: begin
                if (!del_ok) begin
                    plan_report = 1'b1;
                    plan_code   = ST_BAD_POS;
                end else begin
                    plan_walk  = 1'b1;
                    walk_start = pos_m1;
                    walk_end   = pos_m1;
                end
            end
            CMD_LOCATE: begin
                if (empty) begin
                    plan_report = 1'b1;
                    plan_code   = ST_NOTFOUND;
                end else begin
                    plan_walk = 1'b1;
                end
            end
            CMD_DUMP: begin
                if (empty) begin
                    plan_report = 1'b1;
                    plan_code   = ST_EMPTY;
                end else begin
                    plan_walk = 1'b1;
                end
            end
            default: begin
                // Unknown commands pass through finish with no effect.
                plan_report = 1'b0;
            end
        endcase
    end

    assign o_stat.report = plan_report;
    assign o_stat.walk   = plan_walk;
    assign o_stat.at_end = (r_idx == r_end);

    // Next length, applied when the request finishes.
    always_comb begin
        n_len = r_len;
        if (i_ctl.finish) begin
            case (r_cmd)
                CMD_CLEAR:  n_len = '0;
                CMD_INSERT: n_len = r_len + LW'(1);
                CMD_DELETE: n_len = r_len - LW'(1);
                default:    n_len = r_len;
            endcase
        end
    end

    assign cnt_ext = (LW+7)'(n_len);

    // Store writes: shifted words during a walk, the new word at finish.
    always_comb begin
        we = 1'b0;
        wa = ri_p1;
        wd = r_rdata;
        if (r_rv && (r_cmd == CMD_INSERT)) begin
            we = 1'b1;
            wa = ri_p1;
        end else if (r_rv && (r_cmd == CMD_DELETE)) begin
            we = 1'b1;
            wa = ri_m1;
        end else if (i_ctl.finish && (r_cmd == CMD_INSERT)) begin
            we = 1'b1;
            wa = pos_m1;
            wd = r_val;
        end
    end

    // Result selection: immediate report, read-back word, or closing result.
    always_comb begin
        e_vld    = 1'b0;
        e_status = ST_OK;
        e_value  = '0;
        e_last   = 1'b1;
        if (i_ctl.check && plan_report) begin
            e_vld    = 1'b1;
            e_status = plan_code;
        end else if (r_rv && (r_cmd == CMD_GET)) begin
            e_vld   = 1'b1;
            e_value = rd64[31:0];
        end else if (r_rv && (r_cmd == CMD_DUMP)) begin
            e_vld   = 1'b1;
            e_value = rd64[31:0];
            e_last  = (r_ri == len_m1);
        end else if (i_ctl.finish) begin
            case (r_cmd) inside
                CMD_CLEAR, CMD_INSERT, CMD_DELETE: begin
                    e_vld = 1'b1;
                end
                CMD_LOCATE: begin
                    e_vld    = 1'b1;
                    e_status = r_found ? ST_OK : ST_NOTFOUND;
                end
                default: begin
                    e_vld = 1'b0;
                end
            endcase
        end
    end

    // Store write and registered read.
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_rdata <= mem[r_idx];
        end
    end

    // Request capture and walk pointer.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= t_cmd'(i_cmd);
            r_pos <= i_position;
            r_val <= v64[DATA_WIDTH-1:0];
        end
        if (i_ctl.check && plan_walk) begin
            r_idx  <= walk_start;
            r_end  <= walk_end;
            r_down <= walk_down;
        end else if (i_ctl.rd) begin
            r_idx <= r_down ? (r_idx - AW'(1)) : (r_idx + AW'(1));
        end
        if (i_ctl.rd) begin
            r_ri <= r_idx;
        end
        if (i_ctl.check) begin
            r_found <= 1'b0;
        end else if (r_rv && (r_cmd == CMD_LOCATE) && (r_rdata == r_val)) begin
            r_found <= 1'b1;
        end
    end

    // Control state: length and read-valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_rv  <= 1'b0;
        end else begin
            r_len <= n_len;
            r_rv  <= i_ctl.rd;
        end
    end

    // Result registers; only the strobe is reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_vld) begin
            o_status    <= e_status;
            o_value_out <= e_value;
            o_count     <= cnt_ext[6:0];
            o_last      <= e_last;
        end
    end

endmodule

`default_nettype wire

[rtl/core/positional_list_engine.sv]
// Top level of the positional list engine: ordered list with 1-based positions.
// Depends on ple_pkg, ple_ctrl and ple_datapath.
//
//   Channel   Handshake            Fields
//   request   start / busy         i_cmd, i_position, i_value_in
//   result    o_strobe (1 cycle)   o_status, o_value_out, o_count, o_last
//
// A request is taken at an edge with start high and busy low.
// Rejected requests and empty-list results hold busy through the check state
// only. Clear, append at the tail, delete of the last element and unknown
// commands hold busy through check and finish. Shift, get, locate and dump hold
// busy through check, walk, drain and finish, the walk taking n entries through
// the single read port of the store (n up to CAPACITY). The next request can be
// taken once busy is low. Immediate and closing results appear in the first
// cycle with busy low; get and dump results are read from the store and arrive
// while busy is high. Dump gives one result per walked entry, back to back.
// Reset is synchronous, clears the length and leaves the store contents
// undefined. Results cannot be held off by the receiver.
`default_nettype none

module positional_list_engine #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic        [2:0]  i_cmd,
    input  wire logic signed [7:0]  i_position,
    input  wire logic signed [31:0] i_value_in,
    output logic                    o_strobe,
    output logic             [2:0]  o_status,
    output logic signed      [31:0] o_value_out,
    output logic             [6:0]  o_count,
    output logic                    o_last
);
    import ple_pkg::*;

    t_ctl  ctl;
    t_stat stat;

    // Sequencer.
    ple_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_ctl   (ctl),
        .i_stat  (stat)
    );

    // Store, length and result registers.
    ple_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .i_cmd       (i_cmd),
        .i_position  (i_position),
        .i_value_in  (i_value_in),
        .o_strobe    (o_strobe),
        .o_status    (o_status),
        .o_value_out (o_value_out),
        .o_count     (o_count),
        .o_last      (o_last)
    );

`ifndef NO_ASSERTIONS
    // A taken request always leaves the engine busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("engine not busy after taking a request");

    // Every result is produced by a request in progress.
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result produced while idle");

    // The closing result of a request is never followed directly by another.
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("result right after a closing result");

    // Once idle, any result on the port must be the closing one.
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && o_strobe) |-> o_last)
        else $error("non-final result while idle");
`endif

endmodule

`default_nettype wire
